// ===== hdl/iirfir_pkg.sv =====
// Shared types and constants for the direct-form-I IIR/FIR filter.
`default_nettype none

package iirfir_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int COEF_W        = 16;
   localparam int PROD_W        = SAMPLE_W + COEF_W;
   localparam int ACC_W         = PROD_W + 3;
   localparam int NUM_B         = 4;
   localparam int NUM_A         = 3;
   localparam int CSR_IDX_W     = 3;
   localparam int DEFAULT_ORDER = 3;
   localparam int DEFAULT_FRAC  = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_B0  = 3'd0,
      REG_COEF_B1  = 3'd1,
      REG_COEF_B2  = 3'd2,
      REG_COEF_B3  = 3'd3,
      REG_COEF_A1  = 3'd4,
      REG_COEF_A2  = 3'd5,
      REG_COEF_A3  = 3'd6,
      REG_IIR_MODE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                          iir_mode;
      logic [NUM_A-1:0][COEF_W-1:0]  a;
      logic [NUM_B-1:0][COEF_W-1:0]  b;
   } coef_type;

endpackage

`default_nettype wire

// ===== hdl/iirfir_csr.sv =====
// Coefficient and mode registers written through the configuration channel.
`default_nettype none

module iirfir_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [iirfir_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [iirfir_pkg::COEF_W-1:0]    csr_data,
   output      iirfir_pkg::coef_type             coef
);
   import iirfir_pkg::*;

   coef_type coef_ff;
   coef_type coef_in;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_COEF_B0:  coef_in.b[0]     = csr_data;
            REG_COEF_B1:  coef_in.b[1]     = csr_data;
            REG_COEF_B2:  coef_in.b[2]     = csr_data;
            REG_COEF_B3:  coef_in.b[3]     = csr_data;
            REG_COEF_A1:  coef_in.a[0]     = csr_data;
            REG_COEF_A2:  coef_in.a[1]     = csr_data;
            REG_COEF_A3:  coef_in.a[2]     = csr_data;
            REG_IIR_MODE: coef_in.iir_mode = csr_data[0];
            default:      coef_in          = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/iirfir_mac.sv =====
// Parallel multiply-accumulate, rounding and saturation for one sample.
`default_nettype none

module iirfir_mac #(
   parameter int ORDER          = iirfir_pkg::DEFAULT_ORDER,
   parameter int COEF_FRAC_BITS = iirfir_pkg::DEFAULT_FRAC
) (
   input  wire logic [iirfir_pkg::SAMPLE_W-1:0]            sample,
   input  wire logic [ORDER-1:0][iirfir_pkg::SAMPLE_W-1:0] x_hist,
   input  wire logic [ORDER-1:0][iirfir_pkg::SAMPLE_W-1:0] y_hist,
   input  wire iirfir_pkg::coef_type                        coef,
   output      logic [iirfir_pkg::SAMPLE_W-1:0]            y,
   output      logic                                        clip
);
   import iirfir_pkg::*;

   localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(32768));

   logic signed [PROD_W-1:0] prod_b [ORDER+1];
   logic signed [PROD_W-1:0] prod_a [ORDER];
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  q;

   always_comb begin
      prod_b[0] = $signed(coef.b[0]) * $signed(sample);
      for (int k = 1; k <= ORDER; k++) begin
         prod_b[k]   = $signed(coef.b[k]) * $signed(x_hist[k-1]);
         prod_a[k-1] = $signed(coef.a[k-1]) * $signed(y_hist[k-1]);
      end
   end

   always_comb begin
      acc = ACC_W'(prod_b[0]);
      for (int k = 1; k <= ORDER; k++) begin
         acc = acc + ACC_W'(prod_b[k]);
         if (coef.iir_mode) begin
            acc = acc - ACC_W'(prod_a[k-1]);
         end
      end
      q = (acc + RND) >>> COEF_FRAC_BITS;
      if (q > SAT_MAX) begin
         y    = SAMPLE_W'(SAT_MAX);
         clip = 1'b1;
      end else if (q < SAT_MIN) begin
         y    = SAMPLE_W'(SAT_MIN);
         clip = 1'b1;
      end else begin
         y    = q[SAMPLE_W-1:0];
         clip = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/iir_fir_direct_form_filter.sv =====
// Top level of the direct-form-I IIR/FIR filter: handshake, history and result register.
// A sample accepted into the input register is computed by the MAC and stored in the result register.
// Throughput: one sample per cycle while rsp_tready keeps up; on a result-side stall the
// input register holds one pending sample, and one MAC pass closes the feedback loop.
// Reset: synchronous, active high; clears coefficients, mode, histories and valid flags.
`default_nettype none

module iir_fir_direct_form_filter #(
   parameter int ORDER          = iirfir_pkg::DEFAULT_ORDER,
   parameter int COEF_FRAC_BITS = iirfir_pkg::DEFAULT_FRAC
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [iirfir_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [iirfir_pkg::SAMPLE_W-1:0]  rsp_tdata,   // [15:0] sample_out
   output      logic                             rsp_tuser,   // [0] clipped
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [iirfir_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [iirfir_pkg::COEF_W-1:0]    csr_data
);
   import iirfir_pkg::*;

   coef_type                         coef;
   logic                             fire;
   logic [SAMPLE_W-1:0]              mac_y;
   logic                             mac_clip;

   logic                             in_valid_ff,  in_valid_in;
   logic [SAMPLE_W-1:0]              in_sample_ff, in_sample_in;
   logic                             out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]              out_sample_ff, out_sample_in;
   logic                             out_clip_ff,  out_clip_in;
   logic [ORDER-1:0][SAMPLE_W-1:0]   x_hist_ff, x_hist_in;
   logic [ORDER-1:0][SAMPLE_W-1:0]   y_hist_ff, y_hist_in;

   iirfir_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   iirfir_mac #(
      .ORDER          (ORDER),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .sample (in_sample_ff),
      .x_hist (x_hist_ff),
      .y_hist (y_hist_ff),
      .coef   (coef),
      .y      (mac_y),
      .clip   (mac_clip)
   );

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tuser  = out_clip_ff;

   always_comb begin
      in_valid_in   = req_tready ? req_tvalid : in_valid_ff;
      in_sample_in  = (req_tready && req_tvalid) ? req_tdata : in_sample_ff;
      out_valid_in  = fire ? 1'b1 : (out_valid_ff && !rsp_tready);
      out_sample_in = fire ? mac_y : out_sample_ff;
      out_clip_in   = fire ? mac_clip : out_clip_ff;
      x_hist_in     = x_hist_ff;
      y_hist_in     = y_hist_ff;
      if (fire) begin
         for (int k = ORDER - 1; k > 0; k--) begin
            x_hist_in[k] = x_hist_ff[k-1];
            y_hist_in[k] = y_hist_ff[k-1];
         end
         x_hist_in[0] = in_sample_ff;
         y_hist_in[0] = mac_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         x_hist_ff    <= '0;
         y_hist_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         x_hist_ff    <= x_hist_in;
         y_hist_ff    <= y_hist_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff  <= in_sample_in;
      out_sample_ff <= out_sample_in;
      out_clip_ff   <= out_clip_in;
   end

   a_fire_loads_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("computed item did not reach the result register");

   a_feedback_matches_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> (y_hist_ff[0] == out_sample_ff))
      else $error("output history differs from delivered sample");

   a_clip_is_rail: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_clip_ff) |->
         (out_sample_ff == 16'h7fff || out_sample_ff == 16'h8000))
      else $error("clipped flag set on an unsaturated sample");

   a_stalled_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_sample_ff)))
      else $error("pending input item lost while result side stalled");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the direct-form-I IIR/FIR filter: stream traffic, CSR writes.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iirfir_pkg::*;

   localparam int    FRAC        = DEFAULT_FRAC;
   localparam int    TAPS        = DEFAULT_ORDER;
   localparam int    HIST        = 3;
   localparam int    STALL_LIMIT = 1000;
   localparam int    LONG_HOLD   = 80;
   localparam longint SAT_HI     = 32767;
   localparam longint SAT_LO     = -32768;
   localparam logic [SAMPLE_W-1:0] MAX_SAMPLE = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] MIN_SAMPLE = 16'h8000;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                clipped;
   } filtered_type;

   class filter_scoreboard;
      logic signed [COEF_W-1:0]   b_coef [NUM_B];
      logic signed [COEF_W-1:0]   a_coef [NUM_A];
      bit                         feedback_on;
      logic signed [SAMPLE_W-1:0] x_hist [HIST];
      logic signed [SAMPLE_W-1:0] y_hist [HIST];
      filtered_type               filtered_q [$];
      int                         failures;

      function new();
         foreach (b_coef[i]) b_coef[i] = '0;
         foreach (a_coef[i]) a_coef[i] = '0;
         foreach (x_hist[i]) x_hist[i] = '0;
         foreach (y_hist[i]) y_hist[i] = '0;
         feedback_on = 1'b0;
         failures    = 0;
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         failures++;
      endtask

      function int pending();
         return filtered_q.size();
      endfunction

      function void note_config(csr_index_type idx, logic [COEF_W-1:0] value);
         case (idx)
            REG_COEF_B0:  b_coef[0]   = value;
            REG_COEF_B1:  b_coef[1]   = value;
            REG_COEF_B2:  b_coef[2]   = value;
            REG_COEF_B3:  b_coef[3]   = value;
            REG_COEF_A1:  a_coef[0]   = value;
            REG_COEF_A2:  a_coef[1]   = value;
            REG_COEF_A3:  a_coef[2]   = value;
            REG_IIR_MODE: feedback_on = value[0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw);
         longint                     acc;
         longint                     rounded;
         logic signed [SAMPLE_W-1:0] x_now;
         filtered_type               res;
         x_now = raw;
         acc = longint'(b_coef[0]) * longint'(x_now);
         for (int k = 1; k <= TAPS; k++) begin
            acc += longint'(b_coef[k]) * longint'(x_hist[k-1]);
            if (feedback_on)
               acc -= longint'(a_coef[k-1]) * longint'(y_hist[k-1]);
         end
         rounded = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
         res.clipped = 1'b1;
         if (rounded > SAT_HI)
            res.sample = MAX_SAMPLE;
         else if (rounded < SAT_LO)
            res.sample = MIN_SAMPLE;
         else begin
            res.sample  = SAMPLE_W'(rounded);
            res.clipped = 1'b0;
         end
         for (int k = HIST - 1; k > 0; k--) begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
         end
         x_hist[0] = x_now;
         y_hist[0] = res.sample;
         filtered_q.push_back(res);
      endfunction

      task check_result(logic [SAMPLE_W-1:0] data, logic clip);
         filtered_type want;
         if (filtered_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item sample_out=%0d", $signed(data)));
            return;
         end
         want = filtered_q.pop_front();
         if (data !== want.sample)
            report_mismatch($sformatf("sample_out got %0d want %0d",
                                      $signed(data), $signed(want.sample)));
         if (clip !== want.clipped)
            report_mismatch($sformatf("clipped got %b want %b", clip, want.clipped));
      endtask
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index  = REG_COEF_B0;
   logic [COEF_W-1:0]   csr_data   = '0;

   filter_scoreboard filt = new();

   bit calm            = 1'b0;
   int holds_requested = 0;
   int holds_done      = 0;
   int stall_left      = 0;
   int idle_cycles     = 0;
   int samples_sent    = 0;

   iir_fir_direct_form_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            filt.note_config(csr_index, csr_data);
         if (req_tvalid && req_tready)
            filt.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready)
            filt.check_result(rsp_tdata, rsp_tuser);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_requested) begin
         holds_done = holds_requested;
         stall_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   task automatic send_sample(logic [SAMPLE_W-1:0] value);
      int gap;
      gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (filt.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [COEF_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_filter(coef_type c);
      req_tvalid <= 1'b0;
      wait_drained();
      write_reg(REG_COEF_B0, c.b[0]);
      write_reg(REG_COEF_B1, c.b[1]);
      write_reg(REG_COEF_B2, c.b[2]);
      write_reg(REG_COEF_B3, c.b[3]);
      write_reg(REG_COEF_A1, c.a[0]);
      write_reg(REG_COEF_A2, c.a[1]);
      write_reg(REG_COEF_A3, c.a[2]);
      write_reg(REG_IIR_MODE, {{(COEF_W-1){1'b0}}, c.iir_mode});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COEF_W-1:0] pick_coef(int style);
      logic [COEF_W-1:0] pick;
      case (style)
         0: begin
            case ($urandom_range(0, 4))
               0: pick = 16'h7FFF;
               1: pick = 16'h8000;
               2: pick = 16'h0000;
               3: pick = 16'h1000;
               default: pick = 16'hF000;
            endcase
         end
         1: pick = COEF_W'($urandom);
         default: pick = COEF_W'($urandom_range(0, 16'h0C00) - 16'h0600);
      endcase
      return pick;
   endfunction

   function automatic coef_type pick_setting();
      coef_type c;
      int       style;
      style = $urandom_range(0, 4);
      for (int i = 0; i < NUM_B; i++) c.b[i] = pick_coef(style);
      for (int i = 0; i < NUM_A; i++) c.a[i] = pick_coef(style);
      c.iir_mode = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return MAX_SAMPLE;
         1: return MIN_SAMPLE;
         2: return SAMPLE_W'($urandom_range(0, 64) - 32);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      coef_type                   setting;
      logic [SAMPLE_W-1:0]        burst [$];
      int                         count;
      int                         phase;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(MAX_SAMPLE);
      send_sample(MIN_SAMPLE);

      setting.b = {16'hF000, 16'h1000, 16'h8000, 16'h7FFF};
      setting.a = {16'h0001, 16'h8000, 16'h7FFF};
      setting.iir_mode = 1'b0;
      program_filter(setting);
      burst = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                16'h7FFF};
      foreach (burst[i]) send_sample(burst[i]);

      // half-weight tap exercises ties in both directions
      setting.b = {16'h0000, 16'h0000, 16'h0000, 16'h0800};
      setting.a = {16'h0000, 16'h0000, 16'h1000};
      setting.iir_mode = 1'b0;
      program_filter(setting);
      burst = '{16'h0001, 16'hFFFF, 16'h0003, 16'hFFFD};
      foreach (burst[i]) send_sample(burst[i]);

      setting.b = {16'h0000, 16'h0000, 16'h0000, 16'h1000};
      setting.a = {16'h0001, 16'h7FFF, 16'h8000};
      setting.iir_mode = 1'b1;
      program_filter(setting);
      burst = '{16'h0001, 16'h0000, 16'h0000, 16'h0064, 16'h8000, 16'h0000};
      foreach (burst[i]) send_sample(burst[i]);

      phase = 0;
      while (samples_sent < 1100) begin
         program_filter(pick_setting());
         calm  = ($urandom_range(0, 3) == 0);
         count = $urandom_range(60, 140);
         for (int i = 0; i < count; i++) begin
            if (phase == 0 && i == 20)
               holds_requested++;
            if (phase % 3 == 1 && i == count / 2) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            send_sample(pick_sample());
         end
         phase++;
      end

      program_filter(pick_setting());
      calm = 1'b1;
      repeat (100) send_sample(pick_sample());
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (4) @(posedge clock);
      if (filt.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/iirfir_pkg.sv
hdl/iirfir_csr.sv
hdl/iirfir_mac.sv
hdl/iir_fir_direct_form_filter.sv
bench/tb_top.sv
